[hw/rtl/lte_pkg.sv]
// Shared types and constants for the tagged-entry LRU cache.
// Used by the channel interfaces, the controller, the datapath and the top level.
package lte_pkg;

    // Field widths of a request and a response.
    localparam int ACTION_BITS   = 2;
    localparam int DOC_TAG_BITS  = 32;
    localparam int PART_TAG_BITS = 16;
    localparam int DATA_BITS     = 64;
    localparam int STAMP_BITS    = 32;

    // Request action codes.
    localparam logic [ACTION_BITS-1:0] ACT_GET = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_PUT = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_INV = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_NOP = 2'd3;

    // Configuration register file.
    localparam int                  CFG_BITS           = 5;
    localparam int                  APB_ADDR_BITS      = 3;
    localparam int                  APB_DATA_BITS      = 32;
    localparam logic                REG_ENTRIES_USED   = 1'b0;
    localparam logic [CFG_BITS-1:0] ENTRIES_USED_RESET = 5'd16;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic [ACTION_BITS-1:0]   action;
        logic [DOC_TAG_BITS-1:0]  doc_tag;
        logic [PART_TAG_BITS-1:0] part_tag;
        logic [DATA_BITS-1:0]     write_data;
        logic [STAMP_BITS-1:0]    now_time;
    } t_req;

    // One response on the output channel.
    typedef struct packed {
        logic                 hit;
        logic [DATA_BITS-1:0] read_data;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_done;
        logic cmp_busy;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/lte_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on lte_pkg for the payload types.
interface lte_req_if;
    logic          valid;
    logic          ready;
    lte_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lte_rsp_if;
    logic          valid;
    logic          ready;
    lte_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/lte_ctl.sv]
// Controller state machine: sequences load, entry scan and commit of a request.
// Depends on lte_pkg for the command and status structs.
module lte_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output lte_pkg::t_cmd o_cmd,
    input  lte_pkg::t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // Read one entry per cycle, then wait for the last compare.
                if (!i_sts.issue_done) begin
                    o_cmd.issue = 1'b1;
                end else if (!i_sts.cmp_busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // Hold until the response register can take the result.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/lte_dp.sv]
// Datapath: entry memories, valid bits, scan compare, victim choice and response register.
// Depends on lte_pkg; driven by commands from lte_ctl.
module lte_dp #(
    parameter int ENTRIES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lte_pkg::t_cmd                i_cmd,
    output lte_pkg::t_sts                o_sts,
    input  lte_pkg::t_req                i_req,
    input  logic [lte_pkg::CFG_BITS-1:0] i_entries_used,
    input  logic                         i_rsp_ready,
    output logic                         o_rsp_valid,
    output lte_pkg::t_rsp                o_rsp
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KW = (CW > lte_pkg::CFG_BITS) ? CW : lte_pkg::CFG_BITS;

    // Entry storage.
    logic [lte_pkg::DOC_TAG_BITS-1:0]  mem_doc   [ENTRIES];
    logic [lte_pkg::PART_TAG_BITS-1:0] mem_part  [ENTRIES];
    logic [lte_pkg::DATA_BITS-1:0]     mem_data  [ENTRIES];
    logic [lte_pkg::STAMP_BITS-1:0]    mem_stamp [ENTRIES];
    logic [ENTRIES-1:0]                r_valid;

    // Request and scan state.
    lte_pkg::t_req                     r_req;
    logic [CW-1:0]                     r_n;
    logic [CW-1:0]                     r_idx;
    logic                              r_cmp_en;
    logic [IW-1:0]                     r_cmp_idx;
    logic [lte_pkg::DOC_TAG_BITS-1:0]  r_rd_doc;
    logic [lte_pkg::PART_TAG_BITS-1:0] r_rd_part;
    logic [lte_pkg::DATA_BITS-1:0]     r_rd_data;
    logic [lte_pkg::STAMP_BITS-1:0]    r_rd_stamp;

    // Scan results.
    logic                              r_found;
    logic [IW-1:0]                     r_match_idx;
    logic [lte_pkg::DATA_BITS-1:0]     r_match_data;
    logic                              r_free_found;
    logic [IW-1:0]                     r_free_idx;
    logic [lte_pkg::STAMP_BITS-1:0]    r_old_stamp;
    logic [IW-1:0]                     r_old_idx;

    logic                              r_rsp_valid;
    lte_pkg::t_rsp                     r_rsp;

    logic [KW-1:0]                     w_used;
    logic [CW-1:0]                     w_n;
    logic                              w_match;
    logic [IW-1:0]                     w_slot;

    // Clamp the configured count to the range 1 to ENTRIES.
    always_comb begin
        w_used = KW'(i_entries_used);
        if (w_used == '0) begin
            w_n = CW'(1);
        end else if (w_used > KW'(ENTRIES)) begin
            w_n = CW'(ENTRIES);
        end else begin
            w_n = CW'(w_used);
        end
    end

    // Tag compare on the entry read in the previous cycle.
    assign w_match = r_cmp_en && r_valid[r_cmp_idx]
                     && (r_rd_doc == r_req.doc_tag)
                     && (r_rd_part == r_req.part_tag);

    // Put target: matching entry, else first free entry, else the oldest one.
    always_comb begin
        if (r_found) begin
            w_slot = r_match_idx;
        end else if (r_free_found) begin
            w_slot = r_free_idx;
        end else begin
            w_slot = r_old_idx;
        end
    end

    // Status to the controller.
    assign o_sts.issue_done = (r_idx == r_n);
    assign o_sts.cmp_busy   = r_cmp_en;
    assign o_sts.out_free   = !r_rsp_valid || i_rsp_ready;

    // Control state: valid bits, compare enable and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cmp_en    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.issue;
            if (i_cmd.commit && (r_req.action == lte_pkg::ACT_PUT)) begin
                r_valid[w_slot] <= 1'b1;
            end else if (w_match && (r_req.action == lte_pkg::ACT_INV)) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Request capture, scan counter and running scan results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req        <= i_req;
            r_n          <= w_n;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (i_cmd.issue) begin
            r_idx     <= r_idx + CW'(1);
            r_cmp_idx <= r_idx[IW-1:0];
        end
        if (r_cmp_en) begin
            if (w_match && !r_found) begin
                r_found      <= 1'b1;
                r_match_idx  <= r_cmp_idx;
                r_match_data <= r_rd_data;
            end
            if (!r_valid[r_cmp_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
            // Entry 0 seeds the search; later entries win only when strictly older.
            if ((r_cmp_idx == '0) || (r_rd_stamp < r_old_stamp)) begin
                r_old_stamp <= r_rd_stamp;
                r_old_idx   <= r_cmp_idx;
            end
        end
        if (i_cmd.commit) begin
            r_rsp.hit <= r_found && (r_req.action != lte_pkg::ACT_NOP);
            if ((r_req.action == lte_pkg::ACT_GET) && r_found) begin
                r_rsp.read_data <= r_match_data;
            end else begin
                r_rsp.read_data <= '0;
            end
        end
    end

    // Entry memories: one read per scan cycle, one write at commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_doc   <= mem_doc[r_idx[IW-1:0]];
            r_rd_part  <= mem_part[r_idx[IW-1:0]];
            r_rd_data  <= mem_data[r_idx[IW-1:0]];
            r_rd_stamp <= mem_stamp[r_idx[IW-1:0]];
        end
        if (i_cmd.commit) begin
            if (r_req.action == lte_pkg::ACT_PUT) begin
                mem_doc[w_slot]   <= r_req.doc_tag;
                mem_part[w_slot]  <= r_req.part_tag;
                mem_data[w_slot]  <= r_req.write_data;
                mem_stamp[w_slot] <= r_req.now_time;
            end else if ((r_req.action == lte_pkg::ACT_GET) && r_found) begin
                mem_stamp[r_match_idx] <= r_req.now_time;
            end
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[hw/rtl/lru_tagged_entry_cache.sv]
// Fully associative LRU cache of tagged entries: APB register, controller and datapath.
// A request is captured, the scan reads and compares each entry in use, and commit then
// loads the response register once it is free. A new request is accepted only after commit;
// the scan walks the single entry read port one entry per cycle.
// Reset: all valid bits clear and entries_used returns to 16; no clearing pass is needed.
// Depends on lte_pkg, lte_if, lte_ctl and lte_dp.
module lru_tagged_entry_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    lte_req_if.sink                           i_req,
    lte_rsp_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lte_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [lte_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [lte_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    logic [lte_pkg::CFG_BITS-1:0] r_entries_used;
    logic                         w_cfg_wr;
    logic                         w_reg_sel;
    lte_pkg::t_cmd                w_cmd;
    lte_pkg::t_sts                w_sts;

    // Register access decode.
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[lte_pkg::APB_ADDR_BITS-1] == lte_pkg::REG_ENTRIES_USED);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_used <= lte_pkg::ENTRIES_USED_RESET;
        end else if (w_cfg_wr && w_reg_sel) begin
            r_entries_used <= pwdata[lte_pkg::CFG_BITS-1:0];
        end
    end

    assign prdata = w_reg_sel ? lte_pkg::APB_DATA_BITS'(r_entries_used) : '0;

    // Request sequencer.
    lte_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Entry storage and compare datapath.
    lte_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_req          (i_req.data),
        .i_entries_used (r_entries_used),
        .i_rsp_ready    (o_rsp.ready),
        .o_rsp_valid    (o_rsp.valid),
        .o_rsp          (o_rsp.data)
    );

endmodule

[tb/sv/tb_lru_tagged_entry_cache.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the tagged-entry LRU cache: directed and random requests,
// predicted by a shadow copy of the cache. Depends on lte_pkg, lte_if and the cache RTL.
module tb_lru_tagged_entry_cache;

    localparam int CACHE_ENTRIES = 16;
    localparam int QUIET_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 2 * (CACHE_ENTRIES + 4);
    localparam int KEY_POOL      = 40;
    localparam logic [lte_pkg::APB_ADDR_BITS-1:0] ADDR_ENTRIES_USED =
        lte_pkg::APB_ADDR_BITS'(4 * int'(lte_pkg::REG_ENTRIES_USED));

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [lte_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [lte_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [lte_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    lte_req_if req_ch ();
    lte_rsp_if rsp_ch ();

    lru_tagged_entry_cache #(
        .ENTRIES (CACHE_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the cache contents and of the entries_used register.
    logic                              shadow_valid [CACHE_ENTRIES];
    logic [lte_pkg::DOC_TAG_BITS-1:0]  shadow_doc   [CACHE_ENTRIES];
    logic [lte_pkg::PART_TAG_BITS-1:0] shadow_part  [CACHE_ENTRIES];
    logic [lte_pkg::DATA_BITS-1:0]     shadow_data  [CACHE_ENTRIES];
    logic [lte_pkg::STAMP_BITS-1:0]    shadow_stamp [CACHE_ENTRIES];
    logic [lte_pkg::CFG_BITS-1:0]      shadow_used;

    // Responses predicted for accepted requests, oldest first.
    lte_pkg::t_rsp expected_rsp [$];
    lte_pkg::t_rsp want_rsp;

    // Keys that the random traffic draws from, so that hits and evictions are common.
    logic [lte_pkg::DOC_TAG_BITS-1:0]  pool_doc  [KEY_POOL];
    logic [lte_pkg::PART_TAG_BITS-1:0] pool_part [KEY_POOL];

    int                             error_count = 0;
    int                             request_count = 0;
    int                             hit_count = 0;
    int                             setting_count = 0;
    int                             quiet_cycles = 0;
    int                             sender_idle_pct = 0;
    int                             receiver_stall_pct = 0;
    logic [lte_pkg::STAMP_BITS-1:0] clock_stamp = '0;

    // Clock with a 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // A valid entry in use matches when both tags are equal.
    function automatic logic is_match(input int idx, input lte_pkg::t_req r);
        return shadow_valid[idx] && shadow_doc[idx] == r.doc_tag
            && shadow_part[idx] == r.part_tag;
    endfunction

    // Applies one request to the shadow cache and returns the response it must produce.
    function automatic lte_pkg::t_rsp apply_request(input lte_pkg::t_req r);
        int            n;
        int            first;
        int            slot;
        int            i;
        lte_pkg::t_rsp rsp;
        n = (shadow_used == '0) ? 1 :
            (int'(shadow_used) > CACHE_ENTRIES) ? CACHE_ENTRIES : int'(shadow_used);
        rsp = '0;
        first = -1;
        for (i = n - 1; i >= 0; i--) begin
            if (is_match(i, r)) first = i;
        end
        case (r.action)
            lte_pkg::ACT_GET: begin
                if (first >= 0) begin
                    rsp.hit = 1'b1;
                    rsp.read_data = shadow_data[first];
                    shadow_stamp[first] = r.now_time;
                end
            end
            lte_pkg::ACT_PUT: begin
                rsp.hit = (first >= 0);
                slot = first;
                // Without a match, take the lowest free entry, else the oldest stamp.
                if (slot < 0) begin
                    for (i = n - 1; i >= 0; i--) begin
                        if (!shadow_valid[i]) slot = i;
                    end
                end
                if (slot < 0) begin
                    slot = 0;
                    for (i = 1; i < n; i++) begin
                        if (shadow_stamp[i] < shadow_stamp[slot]) slot = i;
                    end
                end
                shadow_valid[slot] = 1'b1;
                shadow_doc[slot]   = r.doc_tag;
                shadow_part[slot]  = r.part_tag;
                shadow_data[slot]  = r.write_data;
                shadow_stamp[slot] = r.now_time;
            end
            lte_pkg::ACT_INV: begin
                // Every matching entry in use is cleared.
                for (i = 0; i < n; i++) begin
                    if (is_match(i, r)) begin
                        shadow_valid[i] = 1'b0;
                        rsp.hit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    function automatic lte_pkg::t_req make_req(
            input logic [lte_pkg::ACTION_BITS-1:0]   act,
            input logic [lte_pkg::DOC_TAG_BITS-1:0]  doc,
            input logic [lte_pkg::PART_TAG_BITS-1:0] part,
            input logic [lte_pkg::DATA_BITS-1:0]     data,
            input logic [lte_pkg::STAMP_BITS-1:0]    stamp);
        lte_pkg::t_req r;
        r.action     = act;
        r.doc_tag    = doc;
        r.part_tag   = part;
        r.write_data = data;
        r.now_time   = stamp;
        return r;
    endfunction

    // Sends one request, starting and ending at a falling edge.
    task automatic send_request(input lte_pkg::t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        expected_rsp.push_back(apply_request(r));
        request_count++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every predicted response has arrived.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge i_clk);
    endtask

    // One register access with its setup and access cycles.
    task automatic apb_access(input logic is_write,
                              input logic [lte_pkg::APB_DATA_BITS-1:0] wdata,
                              output logic [lte_pkg::APB_DATA_BITS-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_ENTRIES_USED;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes entries_used while the cache is idle, then reads it back.
    task automatic set_entries_used(input logic [lte_pkg::CFG_BITS-1:0] value);
        logic [lte_pkg::APB_DATA_BITS-1:0] readback;
        wait_until_drained();
        // Bits above the register are random; the register keeps only its own width.
        apb_access(1'b1, (lte_pkg::APB_DATA_BITS'($urandom()) << lte_pkg::CFG_BITS)
                   | lte_pkg::APB_DATA_BITS'(value), readback);
        shadow_used = value;
        setting_count++;
        apb_access(1'b0, '0, readback);
        if (readback[lte_pkg::CFG_BITS-1:0] !== value) begin
            error_count++;
            $display("%0t: entries_used read back: expected %0d, actual %0d",
                     $time, value, readback[lte_pkg::CFG_BITS-1:0]);
        end
    endtask

    // Get, put, update, partial-tag misses, invalidate and the unused action.
    task automatic test_basic_requests();
        set_entries_used(5'd3);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_request(make_req(lte_pkg::ACT_GET, '1, '1, '0, 32'd1));
        send_request(make_req(lte_pkg::ACT_PUT, '1, '1, '1, 32'd2));
        send_request(make_req(lte_pkg::ACT_GET, '1, '1, '0, 32'd3));
        send_request(make_req(lte_pkg::ACT_GET, '1, '0, '0, 32'd3));
        send_request(make_req(lte_pkg::ACT_GET, '0, '1, '0, 32'd3));
        send_request(make_req(lte_pkg::ACT_PUT, '1, '1, '0, 32'd4));
        send_request(make_req(lte_pkg::ACT_GET, '1, '1, '1, 32'd4));
        send_request(make_req(lte_pkg::ACT_INV, '1, '1, '1, 32'd5));
        send_request(make_req(lte_pkg::ACT_INV, '1, '1, '1, 32'd5));
        send_request(make_req(lte_pkg::ACT_GET, '1, '1, '1, 32'd6));
        send_request(make_req(lte_pkg::ACT_NOP, '1, '1, '1, '1));
    endtask

    // Fill, replacement on equal stamps, and stamp extremes deciding the victim.
    task automatic test_lru_replacement();
        send_request(make_req(lte_pkg::ACT_PUT, '0, '0, 64'h0123_4567_89AB_CDEF, 32'd5));
        send_request(make_req(lte_pkg::ACT_PUT, 32'd1, 16'd1, 64'hFEDC_BA98_7654_3210,
                              32'd5));
        send_request(make_req(lte_pkg::ACT_PUT, 32'd2, 16'd2, 64'hA5A5_5A5A_A5A5_5A5A,
                              32'd5));
        send_request(make_req(lte_pkg::ACT_PUT, 32'd3, 16'd3, 64'h5A5A_A5A5_5A5A_A5A5,
                              32'd6));
        send_request(make_req(lte_pkg::ACT_GET, 32'd1, 16'd1, '0, '0));
        send_request(make_req(lte_pkg::ACT_PUT, 32'd4, 16'd4, 64'h0000_FFFF_0000_FFFF, '1));
        send_request(make_req(lte_pkg::ACT_GET, '0, '0, '0, 32'd7));
    endtask

    // Out-of-range register values, entries kept while out of use, and duplicate keys.
    task automatic test_entries_used_range();
        set_entries_used(5'd0);
        send_request(make_req(lte_pkg::ACT_PUT, 32'd5, 16'd5, 64'h1111_2222_3333_4444,
                              32'd8));
        send_request(make_req(lte_pkg::ACT_GET, 32'd4, 16'd4, '0, 32'd9));
        set_entries_used(5'd31);
        send_request(make_req(lte_pkg::ACT_GET, 32'd4, 16'd4, '0, 32'd10));
        // With one entry in use, the same key lands again in entry 0.
        set_entries_used(5'd1);
        send_request(make_req(lte_pkg::ACT_PUT, 32'd4, 16'd4, 64'h9999_8888_7777_6666,
                              32'd11));
        set_entries_used(5'd16);
        send_request(make_req(lte_pkg::ACT_GET, 32'd4, 16'd4, '0, 32'd12));
        send_request(make_req(lte_pkg::ACT_PUT, 32'd4, 16'd4, 64'hCAFE_F00D_DEAD_BEEF,
                              32'd13));
        send_request(make_req(lte_pkg::ACT_GET, 32'd4, 16'd4, '0, 32'd14));
        send_request(make_req(lte_pkg::ACT_INV, 32'd4, 16'd4, '0, 32'd15));
        send_request(make_req(lte_pkg::ACT_GET, 32'd4, 16'd4, '0, 32'd16));
    endtask

    // Random requests over a key pool sized to the entries in use, with a drain midway.
    task automatic test_random_traffic(input logic [lte_pkg::CFG_BITS-1:0] used,
                                       input int send_pct, input int stall_pct,
                                       input int count);
        int            k;
        int            n;
        int            keys;
        int            pick;
        int            sel;
        lte_pkg::t_req r;
        set_entries_used(used);
        sender_idle_pct = send_pct;
        receiver_stall_pct = stall_pct;
        n = (used == '0) ? 1 : (int'(used) > CACHE_ENTRIES) ? CACHE_ENTRIES : int'(used);
        keys = (2 * n + 2 > KEY_POOL) ? KEY_POOL : 2 * n + 2;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) wait_until_drained();
            pick = $urandom_range(keys - 1);
            sel = $urandom_range(99);
            r.action = (sel < 45) ? lte_pkg::ACT_GET : (sel < 85) ? lte_pkg::ACT_PUT :
                       (sel < 96) ? lte_pkg::ACT_INV : lte_pkg::ACT_NOP;
            r.doc_tag  = pool_doc[pick];
            r.part_tag = pool_part[pick];
            if ($urandom_range(9) == 0) begin
                r.doc_tag  = $urandom();
                r.part_tag = lte_pkg::PART_TAG_BITS'($urandom());
            end
            r.write_data = {$urandom(), $urandom()};
            // Time mostly moves forward in small steps, so equal stamps occur too.
            clock_stamp = clock_stamp + lte_pkg::STAMP_BITS'($urandom_range(3));
            r.now_time = ($urandom_range(31) == 0) ? lte_pkg::STAMP_BITS'($urandom())
                                                   : clock_stamp;
            send_request(r);
        end
    endtask

    // Response ready, stalled at the rate of the current phase.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compares each accepted response with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_rsp.size() == 0) begin
                error_count++;
                $display("%0t: response with none expected: hit %0d, read_data %h",
                         $time, rsp_ch.data.hit, rsp_ch.data.read_data);
            end else begin
                want_rsp = expected_rsp.pop_front();
                if (want_rsp.hit) hit_count++;
                if (rsp_ch.data.hit !== want_rsp.hit) begin
                    error_count++;
                    $display("%0t: hit: expected %0d, actual %0d",
                             $time, want_rsp.hit, rsp_ch.data.hit);
                end
                if (rsp_ch.data.read_data !== want_rsp.read_data) begin
                    error_count++;
                    $display("%0t: read_data: expected %h, actual %h",
                             $time, want_rsp.read_data, rsp_ch.data.read_data);
                end
            end
        end
    end

    // Ends the run when nothing has been accepted for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Reset, directed tests, then random phases with different idle patterns.
    initial begin : main_sequence
        int k;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        shadow_used  = lte_pkg::ENTRIES_USED_RESET;
        for (k = 0; k < CACHE_ENTRIES; k++) begin
            shadow_valid[k] = 1'b0;
            shadow_doc[k]   = '0;
            shadow_part[k]  = '0;
            shadow_data[k]  = '0;
            shadow_stamp[k] = '0;
        end
        // Some keys share a document tag or a part tag with their neighbor.
        for (k = 0; k < KEY_POOL; k++) begin
            pool_doc[k]  = (k % 4 == 1) ? pool_doc[k-1] : $urandom();
            pool_part[k] = (k % 4 == 3) ? pool_part[k-1]
                                        : lte_pkg::PART_TAG_BITS'($urandom());
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_requests();
        test_lru_replacement();
        test_entries_used_range();
        test_random_traffic(5'd16, 0, 0, 300);
        test_random_traffic(5'd5, 53, 0, 250);
        test_random_traffic(5'd1, 0, 53, 100);
        test_random_traffic(5'd17, 18, 18, 300);
        test_random_traffic(5'd12, 0, 0, 200);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests (%0d hits) over %0d entries_used writes,", request_count,
                 hit_count, setting_count);
        $display("with sender gaps and response stalls in separate and combined phases.");
        if (error_count == 0 && expected_rsp.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
